### hdl/ddo_pkg.sv
// Shared types, constants and the arctangent table for the odometry block.
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CORDIC_STAGES_MAX = 32;

    // CORDIC datapath width: Q1.30 values with headroom for growth and sign
    localparam int CW = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] HALF_DIST_RST = 32'd447392;
    localparam logic [31:0] ANGLE_RST     = 32'd1780118;

    // Configuration register indexes
    localparam logic [7:0] CFG_HALF_DIST = 8'd0;
    localparam logic [7:0] CFG_ANGLE     = 8'd1;

    typedef struct packed {
        logic        start;
        logic [31:0] phi;
    } t_cordic_req;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cos_v;
        logic signed [CW-1:0] sin_v;
    } t_cordic_rsp;

    // atan(2^-i) in binary-angle units (full turn = 2^32)
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### hdl/ddo_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module ddo_mul (
    input  logic                           i_clk,
    input  logic signed [ddo_pkg::CW-1:0]  i_a,
    input  logic signed [ddo_pkg::CW-1:0]  i_b,
    output logic signed [2*ddo_pkg::CW-1:0] o_p
);

    logic signed [2*ddo_pkg::CW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### hdl/ddo_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
`timescale 1ns / 1ps

module ddo_cordic #(
    parameter int STAGES = ddo_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ddo_pkg::t_cordic_req i_req,
    output ddo_pkg::t_cordic_rsp o_rsp
);

    // the arctangent table has 32 entries, so longer requests stop there
    localparam int NST = (STAGES > ddo_pkg::CORDIC_STAGES_MAX) ?
                         ddo_pkg::CORDIC_STAGES_MAX : STAGES;
    localparam int CNW = $clog2(NST);
    localparam logic [CNW-1:0] LAST = CNW'(NST - 1);

    typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_FIX} t_cstate;

    t_cstate                       r_state;
    logic [CNW-1:0]                r_cnt;
    logic                          r_flip;
    logic                          r_done;
    logic signed [ddo_pkg::CW-1:0] r_x;
    logic signed [ddo_pkg::CW-1:0] r_y;
    logic signed [ddo_pkg::CW-1:0] r_z;

    logic                          w_flip;
    logic [31:0]                   w_a;
    logic signed [ddo_pkg::CW-1:0] w_xs;
    logic signed [ddo_pkg::CW-1:0] w_ys;
    logic signed [ddo_pkg::CW-1:0] w_at;

    // second and third quarters fold by a half turn, results negated at the end
    assign w_flip = i_req.phi[31] ^ i_req.phi[30];
    assign w_a    = i_req.phi ^ {w_flip, 31'd0};
    assign w_xs   = r_x >>> r_cnt;
    assign w_ys   = r_y >>> r_cnt;
    assign w_at   = {2'b00, ddo_pkg::atan_lut(5'(r_cnt))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= (r_state == CS_FIX);
            unique case (r_state)
                CS_IDLE: begin
                    if (i_req.start) begin
                        r_x     <= ddo_pkg::CORDIC_GAIN;
                        r_y     <= '0;
                        r_z     <= {{2{w_a[31]}}, w_a};
                        r_flip  <= w_flip;
                        r_cnt   <= '0;
                        r_state <= CS_RUN;
                    end
                end
                CS_RUN: begin
                    if (!r_z[ddo_pkg::CW-1]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                    if (r_cnt == LAST) begin
                        r_state <= CS_FIX;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                CS_FIX: begin
                    if (r_flip) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                    end
                    r_state <= CS_IDLE;
                end
                default: r_state <= CS_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.cos_v = r_x;
    assign o_rsp.sin_v = r_y;

endmodule

### hdl/differential_drive_odometry.sv
// Top level: differential-drive wheel odometry with a sequenced shared datapath.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream carries cumulative encoder counts: tdata = {right, left}
//   (left in bits 31:0), tuser = kind (0 reference, 1 motion). A reference word
//   latches the counts and clears the pose. A motion word integrates the
//   wrapping tick deltas into x, y (Q16.16 m) and heading (binary angle).
//   Master stream returns one word per input word with the pose and deltas.
//   Configuration channel writes half metres per tick (index 0) and angle
//   units per tick of right minus left (index 1); it is always ready.
//   Sequence: a motion word passes through the sum, two products, the
//   rotation by the iterative CORDIC (one micro-rotation per cycle), two
//   more products and the pose update; all four products share one
//   multiplier. A reference word goes from acceptance straight to the
//   result stage. Input ready is high only while the sequencer is idle, so
//   a new word is accepted only after the previous one has left the sequencer.
//   The result sits in an output register; a new word can be accepted while
//   it waits, and the sequencer holds its finished pose until the receiver
//   takes the previous one. Reset (synchronous, active low) clears the pose,
//   the stored counts and restores the default scale registers.

module differential_drive_odometry #(
    parameter int CORDIC_STAGES = ddo_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // [31:0] left_count, [63:32] right_count
    input  logic [0:0]   i_s_axis_tuser,   // [0] kind
    // master stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [159:0] o_m_axis_tdata,   // x_pos, y_pos, heading, left_delta, right_delta
    // configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int W = ddo_pkg::CW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SUM, ST_MUL_S, ST_MUL_T, ST_ROT, ST_WAIT,
        ST_MUL_X, ST_MUL_Y, ST_UPD, ST_DONE
    } t_state;

    t_state       r_state;
    logic [31:0]  r_half_dist;
    logic [31:0]  r_angle;
    logic [31:0]  r_prev_l;
    logic [31:0]  r_prev_r;
    logic [31:0]  r_x;
    logic [31:0]  r_y;
    logic [31:0]  r_hd;
    logic [31:0]  r_dl;
    logic [31:0]  r_dr;
    logic [32:0]  r_sum;
    logic [32:0]  r_diff;
    logic [31:0]  r_sq;
    logic [31:0]  r_dth;
    logic         r_m_valid;
    logic [159:0] r_m_data;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic signed [W-1:0]   w_a;
    logic signed [W-1:0]   w_b;
    logic signed [2*W-1:0] w_p;
    logic [47:0]           w_s_rnd;
    logic [61:0]           w_inc_rnd;
    logic [31:0]           w_inc;
    ddo_pkg::t_cordic_req  w_req;
    ddo_pkg::t_cordic_rsp  w_rsp;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_m_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // rounding of the travel and of the position increments
    assign w_s_rnd   = w_p[47:0] + 48'd32768;
    assign w_inc_rnd = w_p[61:0] + 62'd536870912;
    assign w_inc     = w_inc_rnd[61:30];

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            ST_MUL_S: begin
                w_a = {r_sum[32], r_sum};
                w_b = {2'b00, r_half_dist};
            end
            ST_MUL_T: begin
                w_a = {r_diff[32], r_diff};
                w_b = {2'b00, r_angle};
            end
            ST_MUL_X: begin
                w_a = {{2{r_sq[31]}}, r_sq};
                w_b = w_rsp.cos_v;
            end
            ST_MUL_Y: begin
                w_a = {{2{r_sq[31]}}, r_sq};
                w_b = w_rsp.sin_v;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // heading plus half the turn: product bits 32:1 are the floor halving
    assign w_req.start = (r_state == ST_ROT);
    assign w_req.phi   = r_hd + w_p[32:1];

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    ddo_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_half_dist <= ddo_pkg::HALF_DIST_RST;
            r_angle     <= ddo_pkg::ANGLE_RST;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_hd        <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ddo_pkg::CFG_HALF_DIST: r_half_dist <= i_cfg_data;
                    ddo_pkg::CFG_ANGLE:     r_angle     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == ST_DONE && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_prev_l <= i_s_axis_tdata[31:0];
                        r_prev_r <= i_s_axis_tdata[63:32];
                        if (i_s_axis_tuser[0]) begin
                            r_dl    <= i_s_axis_tdata[31:0] - r_prev_l;
                            r_dr    <= i_s_axis_tdata[63:32] - r_prev_r;
                            r_state <= ST_SUM;
                        end else begin
                            r_dl    <= '0;
                            r_dr    <= '0;
                            r_x     <= '0;
                            r_y     <= '0;
                            r_hd    <= '0;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SUM: begin
                    r_sum   <= {r_dl[31], r_dl} + {r_dr[31], r_dr};
                    r_diff  <= {r_dr[31], r_dr} - {r_dl[31], r_dl};
                    r_state <= ST_MUL_S;
                end
                ST_MUL_S: r_state <= ST_MUL_T;
                ST_MUL_T: begin
                    r_sq    <= w_s_rnd[47:16];
                    r_state <= ST_ROT;
                end
                ST_ROT: begin
                    r_dth   <= w_p[31:0];
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_rsp.done) begin
                        r_state <= ST_MUL_X;
                    end
                end
                ST_MUL_X: r_state <= ST_MUL_Y;
                ST_MUL_Y: begin
                    r_x     <= r_x + w_inc;
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_y     <= r_y + w_inc;
                    r_hd    <= r_hd + r_dth;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_m_data  <= {r_dr, r_dl, r_hd, r_y, r_x};
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // the rotation unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == ST_WAIT)
        else $error("rotation result outside wait state");

    // a reference word clears the heading at once
    a_ref_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_s_axis_tuser[0]) |=> (r_hd == '0 && r_state == ST_DONE))
        else $error("reference word did not clear pose");

    // a motion word enters the datapath sequence
    a_motion_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tuser[0]) |=> r_state == ST_SUM)
        else $error("motion word did not start sequence");

    // a new result is loaded only when the previous one is gone or leaving
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_m_valid && !i_m_axis_tready) |=> r_state == ST_DONE)
        else $error("result overwritten while stalled");

endmodule
